/* src/ias_pkg.sv */
// Shared types and constants for the integer array sorter.
`timescale 1ns / 1ps

package ias_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_e;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

/* src/ias_cell.sv */
// One cell of the insertion chain: holds a single element and its valid flag.
`timescale 1ns / 1ps

module ias_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ias_pkg::cell_ctrl_t                 ctrl_i,
  input  logic signed [ias_pkg::DATA_W-1:0]   new_val_i,
  input  logic signed [ias_pkg::DATA_W-1:0]   left_val_i,
  input  logic                                left_valid_i,
  input  logic                                left_gt_i,
  input  logic signed [ias_pkg::DATA_W-1:0]   right_val_i,
  input  logic                                right_valid_i,
  output logic signed [ias_pkg::DATA_W-1:0]   val_o,
  output logic                                valid_o,
  output logic                                gt_o
);

  logic signed [ias_pkg::DATA_W-1:0] val_q, val_d;
  logic                              valid_q, valid_d;

  // An empty cell behaves as plus infinity, so the greater-than flags along
  // the chain form a single step at the insertion point.
  assign gt_o = !valid_q || (val_q > new_val_i);

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    if (ctrl_i.shift) begin
      val_d   = right_val_i;
      valid_d = right_valid_i;
    end else if (ctrl_i.load && gt_o) begin
      val_d   = left_gt_i ? left_val_i : new_val_i;
      valid_d = valid_q | left_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o   = val_q;
  assign valid_o = valid_q;

endmodule

/* src/integer_array_sort.sv */
// Top level of the integer array sorter: insertion cell chain and drain control.
//
//   channel   direction  handshake                    payload
//   command   in         start_i / busy_o             value_i, last_element_i
//   result    out        result_valid_o (strobe)      sorted_value_o, last_out_o, dropped_o
//
// Loading: every cell compares with each accepted element in parallel and the
// chain shifts right from the insertion point in the same cycle.
// After an element marked last, busy_o stays high while the chain shifts left
// and cell 0 is emitted each cycle, until the last stored element is out.
// Reset empties the chain at once; no clearing pass is needed.
// Results cannot be stalled; one result is presented in every draining cycle.
`timescale 1ns / 1ps

module integer_array_sort #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [ias_pkg::DATA_W-1:0] value_i,
  input  logic                              last_element_i,
  output logic                              result_valid_o,
  output logic signed [ias_pkg::DATA_W-1:0] sorted_value_o,
  output logic                              last_out_o,
  output logic                              dropped_o
);

  ias_pkg::state_e    state_q, state_d;
  logic               overflow_q, overflow_d;
  ias_pkg::cell_ctrl_t ctrl;
  logic               accept;
  logic               full;
  logic               final_result;

  logic signed [ias_pkg::DATA_W-1:0] cell_val   [MAX_ELEMENTS];
  logic                              cell_valid [MAX_ELEMENTS];
  logic                              cell_gt    [MAX_ELEMENTS];

  assign accept       = start_i && (state_q == ias_pkg::ST_LOAD);
  assign full         = cell_valid[MAX_ELEMENTS-1];
  assign final_result = (state_q == ias_pkg::ST_DRAIN) && !cell_valid[1];

  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    logic signed [ias_pkg::DATA_W-1:0] left_val, right_val;
    logic                              left_valid, left_gt, right_valid;

    if (i == 0) begin : g_head
      assign left_val   = value_i;
      assign left_valid = 1'b1;
      assign left_gt    = 1'b0;
    end else begin : g_body
      assign left_val   = cell_val[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    if (i == MAX_ELEMENTS - 1) begin : g_tail
      assign right_val   = value_i;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_val   = cell_val[i+1];
      assign right_valid = cell_valid[i+1];
    end

    ias_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_val_i     (value_i),
      .left_val_i    (left_val),
      .left_valid_i  (left_valid),
      .left_gt_i     (left_gt),
      .right_val_i   (right_val),
      .right_valid_i (right_valid),
      .val_o         (cell_val[i]),
      .valid_o       (cell_valid[i]),
      .gt_o          (cell_gt[i])
    );
  end

  // Next state and overflow flag.
  always_comb begin
    state_d    = state_q;
    overflow_d = overflow_q;
    unique case (state_q)
      ias_pkg::ST_LOAD: begin
        if (accept) begin
          if (full) begin
            overflow_d = 1'b1;
          end
          if (last_element_i) begin
            state_d = ias_pkg::ST_DRAIN;
          end
        end
      end
      ias_pkg::ST_DRAIN: begin
        if (final_result) begin
          state_d    = ias_pkg::ST_LOAD;
          overflow_d = 1'b0;
        end
      end
      default: begin
        state_d = ias_pkg::ST_LOAD;
      end
    endcase
  end

  // Chain commands and port outputs.
  always_comb begin
    ctrl.load      = 1'b0;
    ctrl.shift     = 1'b0;
    busy_o         = 1'b0;
    result_valid_o = 1'b0;
    last_out_o     = 1'b0;
    dropped_o      = 1'b0;
    unique case (state_q)
      ias_pkg::ST_LOAD: begin
        ctrl.load = accept && !full;
      end
      ias_pkg::ST_DRAIN: begin
        ctrl.shift     = 1'b1;
        busy_o         = 1'b1;
        result_valid_o = 1'b1;
        last_out_o     = final_result;
        dropped_o      = final_result && overflow_q;
      end
      default: begin
        ctrl.load = 1'b0;
      end
    endcase
  end

  assign sorted_value_o = cell_val[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ias_pkg::ST_LOAD;
      overflow_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      overflow_q <= overflow_d;
    end
  end

endmodule

/* src/ias_checker.sv */
// Port-level checks for the integer array sorter, bound to the top level.
`timescale 1ns / 1ps

module ias_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic last_element_i,
  input logic result_valid_o,
  input logic last_out_o,
  input logic dropped_o
);

  // Results only appear while the block refuses new commands.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o)
    else $error("result presented while not busy");

  // The drop flag belongs to the final result of a run only.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dropped_o |-> (last_out_o && result_valid_o))
    else $error("dropped flag outside the final result");

  // After the final result the block is free again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_out_o) |=> (!result_valid_o && !busy_o))
    else $error("activity continued after the final result");

  // An unmarked transaction produces no result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !last_element_i) |=> !result_valid_o)
    else $error("result without a last-marked transaction");

  // A last-marked transaction always starts a run of results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_element_i) |=> result_valid_o)
    else $error("no result after a last-marked transaction");

endmodule

bind integer_array_sort ias_checker u_ias_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .last_element_i (last_element_i),
  .result_valid_o (result_valid_o),
  .last_out_o     (last_out_o),
  .dropped_o      (dropped_o)
);
